### hw/rtl/pwmts_pkg.sv
// Shared constants, codes and types of the timestamp-driven PWM generator.
package pwmts_pkg;

   // Number of PWM channels and the derived channel index width.
   localparam int CHANNELS = 8;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Field widths of the request and response items.
   localparam int REQ_TYPE_W = 2;
   localparam int COUNT_W    = 32;
   localparam int CHAN_W     = 3;
   localparam int MASK_W     = 8;
   localparam int STAMP_W    = 64;

   // Request codes carried in the req_type field.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_TICK = 2'd0,
      REQ_CHAN = 2'd1,
      REQ_MASK = 2'd2
   } req_code_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // Stored state of one channel, as read from the channel store.
   typedef struct packed {
      logic [STAMP_W-1:0] rise;
      logic [STAMP_W-1:0] fall;
      logic [COUNT_W-1:0] period;
      logic [COUNT_W-1:0] high;
      logic               latched;
   } chan_rd_type;

   // Update of one channel produced by the shared stamp unit.
   typedef struct packed {
      logic               rise_hit;
      logic               fall_hit;
      logic               set_pin;
      logic               clr_pin;
      logic [STAMP_W-1:0] rise;
      logic [STAMP_W-1:0] fall;
      logic               latched;
   } chan_upd_type;

endpackage

### hw/rtl/pwmts_if.sv
// Valid/ready channel interfaces for request and response items.
interface pwmts_req_if;
   import pwmts_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [COUNT_W-1:0]    counter_value;
   logic [CHAN_W-1:0]     channel;
   logic [COUNT_W-1:0]    period_ticks;
   logic [COUNT_W-1:0]    high_ticks;
   logic [MASK_W-1:0]     enable_bits;

   modport source (
      output valid, req_type, counter_value, channel, period_ticks, high_ticks, enable_bits,
      input  ready
   );
   modport sink (
      input  valid, req_type, counter_value, channel, period_ticks, high_ticks, enable_bits,
      output ready
   );
endinterface

interface pwmts_rsp_if;
   import pwmts_pkg::*;

   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] pin_levels;
   logic [MASK_W-1:0] rise_events;
   logic [MASK_W-1:0] fall_events;

   modport source (
      output valid, pin_levels, rise_events, fall_events,
      input  ready
   );
   modport sink (
      input  valid, pin_levels, rise_events, fall_events,
      output ready
   );
endinterface

### hw/rtl/pwmts_chan_store.sv
// Per-channel stamp, enable and period/high storage with one read port, one stamp update port and one table write port.
module pwmts_chan_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [pwmts_pkg::CH_W-1:0] rd_idx,
   output pwmts_pkg::chan_rd_type     rd,
   input  logic                       upd_en,
   input  pwmts_pkg::chan_upd_type    upd,
   input  logic                       tbl_we,
   input  logic [pwmts_pkg::CH_W-1:0] tbl_idx,
   input  logic [pwmts_pkg::COUNT_W-1:0] tbl_period,
   input  logic [pwmts_pkg::COUNT_W-1:0] tbl_high
);
   import pwmts_pkg::*;

   logic [STAMP_W-1:0] rise_ff    [CHANNELS];
   logic [STAMP_W-1:0] fall_ff    [CHANNELS];
   logic [COUNT_W-1:0] period_ff  [CHANNELS];
   logic [COUNT_W-1:0] high_ff    [CHANNELS];
   logic [CHANNELS-1:0] latched_ff;

   // The channel under scan is read directly.
   always_comb begin
      rd.rise    = rise_ff[rd_idx];
      rd.fall    = fall_ff[rd_idx];
      rd.period  = period_ff[rd_idx];
      rd.high    = high_ff[rd_idx];
      rd.latched = latched_ff[rd_idx];
   end

   // Stamp updates from the scan and table writes from requests.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            rise_ff[i]   <= '0;
            fall_ff[i]   <= '0;
            period_ff[i] <= '0;
            high_ff[i]   <= '0;
         end
         latched_ff <= '0;
      end else begin
         if (upd_en && upd.rise_hit) begin
            rise_ff[rd_idx]    <= upd.rise;
            fall_ff[rd_idx]    <= upd.fall;
            latched_ff[rd_idx] <= upd.latched;
         end else if (upd_en && upd.fall_hit) begin
            fall_ff[rd_idx] <= upd.fall;
         end
         if (tbl_we) begin
            period_ff[tbl_idx] <= tbl_period;
            high_ff[tbl_idx]   <= tbl_high;
         end
      end
   end
endmodule

### hw/rtl/pwmts_stamp_unit.sv
// Shared compare and add unit that decides the rise or fall of one channel.
module pwmts_stamp_unit (
   input  logic [pwmts_pkg::STAMP_W-1:0] now,
   input  pwmts_pkg::chan_rd_type        rd,
   input  logic                          en_bit,
   output pwmts_pkg::chan_upd_type       upd
);
   import pwmts_pkg::*;

   logic               rise_reached;
   logic               fall_reached;
   logic [STAMP_W-1:0] now_plus_period;
   logic [STAMP_W-1:0] now_plus_high;

   // Deadlines count as reached when the time equals or passes them.
   assign rise_reached    = (now >= rd.rise);
   assign fall_reached    = (now >= rd.fall);
   assign now_plus_period = now + {{(STAMP_W-COUNT_W){1'b0}}, rd.period};
   assign now_plus_high   = now + {{(STAMP_W-COUNT_W){1'b0}}, rd.high};

   // A reached rise takes precedence; the fall is examined only otherwise.
   always_comb begin
      upd.rise_hit = rise_reached;
      upd.fall_hit = !rise_reached && fall_reached;
      upd.latched  = en_bit;
      upd.rise     = now_plus_period;
      upd.fall     = rise_reached ? now_plus_high : now_plus_period;
      upd.set_pin  = rise_reached && en_bit;
      upd.clr_pin  = !rise_reached && fall_reached && rd.latched;
   end
endmodule

### hw/rtl/multi_channel_pwm_timestamp_generator.sv
// Top level of the multi-channel PWM generator driven by counter timestamps.
//
// A tick item widens its 32-bit counter reading to a 64-bit time by counting
// wraps, then visits the channels one per cycle through a single shared
// compare/add unit, which walks the channel store; the tick's result item is
// registered once the last channel has been visited. Period/high writes,
// enable mask writes and unused request codes register their result item
// on acceptance, with no scan. A new item is accepted while the previous
// result is being taken; there is no clearing pass, as the control state and
// the channel store reset directly.
module multi_channel_pwm_timestamp_generator (
   input  logic        clock,
   input  logic        reset,
   pwmts_req_if.sink   req,
   pwmts_rsp_if.source rsp
);
   import pwmts_pkg::*;

   state_type            state_ff, state_in;
   logic [CH_W-1:0]      idx_ff, idx_in;
   logic [COUNT_W-1:0]   upper_ff, upper_in;
   logic [COUNT_W-1:0]   prev_ff, prev_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic [CHANNELS-1:0]  pin_ff, pin_in;
   logic [CHANNELS-1:0]  rise_acc_ff, rise_acc_in;
   logic [CHANNELS-1:0]  fall_acc_ff, fall_acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]    rsp_pin_ff, rsp_pin_in;
   logic [MASK_W-1:0]    rsp_rise_ff, rsp_rise_in;
   logic [MASK_W-1:0]    rsp_fall_ff, rsp_fall_in;

   logic                    accept;
   logic                    scanning;
   logic                    last_chan;
   logic                    tbl_we;
   logic [STAMP_W-1:0]      now;
   logic [CHANNELS+MASK_W-1:0] en_wide;
   logic [CHANNELS-1:0]     en_vec;
   logic [CHANNELS+MASK_W-1:0] pin_wide;
   logic [CHANNELS+MASK_W-1:0] rise_wide;
   logic [CHANNELS+MASK_W-1:0] fall_wide;
   chan_rd_type             rd;
   chan_upd_type            upd;

   // Handshake: one item at a time, output register free or being drained.
   assign req.ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept     = req.valid && req.ready;
   assign scanning   = (state_ff == ST_SCAN);
   assign last_chan  = (idx_ff == CH_W'(CHANNELS - 1));
   assign now        = {upper_ff, prev_ff};

   // Channels at index 8 and above can never be enabled.
   assign en_wide = {{CHANNELS{1'b0}}, mask_ff};
   assign en_vec  = en_wide[CHANNELS-1:0];

   // Period/high writes to channels beyond the channel count are dropped.
   assign tbl_we = accept && (req_code_type'(req.req_type) == REQ_CHAN) &&
                   ({{(COUNT_W-CHAN_W){1'b0}}, req.channel} < COUNT_W'(CHANNELS));

   pwmts_chan_store u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_idx     (idx_ff),
      .rd         (rd),
      .upd_en     (scanning),
      .upd        (upd),
      .tbl_we     (tbl_we),
      .tbl_idx    (CH_W'(req.channel)),
      .tbl_period (req.period_ticks),
      .tbl_high   (req.high_ticks)
   );

   pwmts_stamp_unit u_unit (
      .now    (now),
      .rd     (rd),
      .en_bit (en_vec[idx_ff]),
      .upd    (upd)
   );

   // Pins and event masks as they stand after the channel under scan; accepting a tick clears the event masks.
   always_comb begin
      pin_in      = pin_ff;
      rise_acc_in = rise_acc_ff;
      fall_acc_in = fall_acc_ff;
      if (accept && (req_code_type'(req.req_type) == REQ_TICK)) begin
         rise_acc_in = '0;
         fall_acc_in = '0;
      end else if (scanning) begin
         if (upd.set_pin) pin_in[idx_ff] = 1'b1;
         if (upd.clr_pin) pin_in[idx_ff] = 1'b0;
         if (upd.rise_hit) rise_acc_in[idx_ff] = 1'b1;
         if (upd.fall_hit) fall_acc_in[idx_ff] = 1'b1;
      end
   end

   // Narrow the per-channel vectors to the 8-bit result fields.
   assign pin_wide  = {{MASK_W{1'b0}}, pin_in};
   assign rise_wide = {{MASK_W{1'b0}}, rise_acc_in};
   assign fall_wide = {{MASK_W{1'b0}}, fall_acc_in};

   // Sequencer, time widening, mask register and result register.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      upper_in     = upper_ff;
      prev_in      = prev_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pin_in   = rsp_pin_ff;
      rsp_rise_in  = rsp_rise_ff;
      rsp_fall_in  = rsp_fall_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_code_type'(req.req_type))
                  REQ_TICK: begin
                     if (prev_ff > req.counter_value) upper_in = upper_ff + 1'b1;
                     prev_in  = req.counter_value;
                     idx_in   = '0;
                     state_in = ST_SCAN;
                  end
                  REQ_MASK: begin
                     mask_in = req.enable_bits;
                  end
                  default: begin
                  end
               endcase
               if (req_code_type'(req.req_type) != REQ_TICK) begin
                  rsp_valid_in = 1'b1;
                  rsp_pin_in   = pin_wide[MASK_W-1:0];
                  rsp_rise_in  = '0;
                  rsp_fall_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (last_chan) begin
               idx_in       = '0;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_pin_in   = pin_wide[MASK_W-1:0];
               rsp_rise_in  = rise_wide[MASK_W-1:0];
               rsp_fall_in  = fall_wide[MASK_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         upper_ff     <= '0;
         prev_ff      <= '0;
         mask_ff      <= '0;
         pin_ff       <= '0;
         rise_acc_ff  <= '0;
         fall_acc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         upper_ff     <= upper_in;
         prev_ff      <= prev_in;
         mask_ff      <= mask_in;
         pin_ff       <= pin_in;
         rise_acc_ff  <= rise_acc_in;
         fall_acc_ff  <= fall_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_pin_ff  <= rsp_pin_in;
      rsp_rise_ff <= rsp_rise_in;
      rsp_fall_ff <= rsp_fall_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pin_levels  = rsp_pin_ff;
   assign rsp.rise_events = rsp_rise_ff;
   assign rsp.fall_events = rsp_fall_ff;
endmodule
